// ===== rtl/core/mbet_pkg.sv =====
`default_nettype none

package mbet_pkg;

  // Coordinate word: signed fixed point, fraction width set by FRAC_BITS
  localparam int unsigned WordWidth     = 32;
  localparam int unsigned LimitWidth    = 16;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned QueueDepth    = 2;

  localparam int unsigned FracBitsDef   = 28;
  localparam int unsigned CoordWidthDef = 12;
  localparam int unsigned CountWidthDef = 16;

  localparam logic [LimitWidth-1:0] LimitReset = LimitWidth'(256);
  localparam logic [WordWidth-1:0]  WordMax    = {1'b0, {(WordWidth-1){1'b1}}};
  localparam logic [WordWidth-1:0]  WordMin    = {1'b1, {(WordWidth-1){1'b0}}};

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CORNER_REAL     = 3'd0,
    REG_CORNER_IMAG     = 3'd1,
    REG_STEP_REAL       = 3'd2,
    REG_STEP_IMAG       = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [WordWidth-1:0] corner_real;
    logic signed [WordWidth-1:0] corner_imag;
    logic signed [WordWidth-1:0] step_real;
    logic signed [WordWidth-1:0] step_imag;
  } view_cfg_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] c_real;
    logic signed [WordWidth-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic   valid;
    point_t point;
  } push_t;

  typedef struct packed {
    logic   valid;
    point_t point;
  } head_t;

endpackage

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time.sv =====
`default_nettype none

// Mandelbrot escape-time counter. Each request carries one pixel (pixel_x, pixel_y);
// the block maps it to c = corner + step * pixel in signed fixed point with FRAC_BITS
// fraction bits in a 32-bit word (Q4.28 by default), saturating at the word bounds,
// then iterates z = z*z + c from zero and returns how many iterations kept |z|^2 at
// or below 4, capped at iteration_limit. Squares are exact and the escape test is
// exact; each new part of z is floored and saturated. A front stage takes a request,
// forms c through its IDLE, MUL and PUSH states and drops it into a two-entry queue;
// the iteration engine behind the queue runs each iteration as a B_MUL state for
// the three 32x32 products and a B_ADD state for the add, saturation and escape
// compare, and holds a finished count in B_DONE while the output stalls; the front
// can accept the next pixels while the engine runs. Results leave through an
// output register.
// Program the five registers (corner_real, corner_imag, step_real, step_imag,
// iteration_limit at indexes 0 to 4) only while no request is in flight; writes to
// other indexes are dropped. The config channel never back-pressures.

module mandelbrot_escape_time import mbet_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [WordWidth-1:0]   cfg_data_i,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [COORD_WIDTH-1:0] pixel_x_i,
  input  wire logic [COORD_WIDTH-1:0] pixel_y_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [COUNT_WIDTH-1:0]      escape_count_o
);

  view_cfg_t             view_q;
  logic [LimitWidth-1:0] limit_q;
  push_t                 push;
  logic                  queue_full;
  head_t                 head;
  logic                  pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes fall through and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q  <= '0;
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CORNER_REAL:     view_q.corner_real <= $signed(cfg_data_i);
        REG_CORNER_IMAG:     view_q.corner_imag <= $signed(cfg_data_i);
        REG_STEP_REAL:       view_q.step_real   <= $signed(cfg_data_i);
        REG_STEP_IMAG:       view_q.step_imag   <= $signed(cfg_data_i);
        REG_ITERATION_LIMIT: limit_q            <= cfg_data_i[LimitWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: take a pixel, form the point c, hand it to the queue
  mbet_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (view_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .push_o     (push),
    .full_i     (queue_full)
  );

  // Decouple the front from the iteration engine
  mbet_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back: iterate z until escape or limit, hold the count for the consumer
  mbet_iter #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_iter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limit_i        (limit_q),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mbet_queue.sv =====
`default_nettype none

module mbet_queue import mbet_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       full_o,
  output head_t      head_o,
  input  wire logic  pop_i
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  point_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == CntWidth'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.point = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.point;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(QueueDepth))
    else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mbet_front.sv =====
`default_nettype none

module mbet_front import mbet_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire view_cfg_t              cfg_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [COORD_WIDTH-1:0] pixel_x_i,
  input  wire logic [COORD_WIDTH-1:0] pixel_y_i,
  output push_t                       push_o,
  input  wire logic                   full_i
);

  localparam int unsigned ProdWidth = WordWidth + COORD_WIDTH + 1;
  localparam int unsigned SumWidth  = ProdWidth + 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  front_state_e                state_q;
  logic [COORD_WIDTH-1:0]      px_q, py_q;
  logic signed [ProdWidth-1:0] prod_re_q, prod_im_q;
  logic signed [ProdWidth-1:0] prod_re_c, prod_im_c;
  logic signed [SumWidth-1:0]  sum_re, sum_im;
  logic [SumWidth-WordWidth:0] hi_re, hi_im;
  logic [WordWidth-1:0]        c_re, c_im;

  assign prod_re_c = cfg_i.step_real * $signed({1'b0, px_q});
  assign prod_im_c = cfg_i.step_imag * $signed({1'b0, py_q});

  assign sum_re = SumWidth'(prod_re_q) + SumWidth'(cfg_i.corner_real);
  assign sum_im = SumWidth'(prod_im_q) + SumWidth'(cfg_i.corner_imag);

  // Saturate to the word range: upper bits must all agree with the word's sign
  assign hi_re = sum_re[SumWidth-1:WordWidth-1];
  assign hi_im = sum_im[SumWidth-1:WordWidth-1];
  assign c_re  = ((&hi_re) || !(|hi_re)) ? sum_re[WordWidth-1:0]
               : (sum_re[SumWidth-1] ? WordMin : WordMax);
  assign c_im  = ((&hi_im) || !(|hi_im)) ? sum_im[WordWidth-1:0]
               : (sum_im[SumWidth-1] ? WordMin : WordMax);

  assign in_stall_o         = (state_q != F_IDLE);
  assign push_o.valid       = (state_q == F_PUSH) && !full_i;
  assign push_o.point.c_real = $signed(c_re);
  assign push_o.point.c_imag = $signed(c_im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (state_q == F_MUL) begin
      prod_re_q <= prod_re_c;
      prod_im_q <= prod_im_c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbet_iter.sv =====
`default_nettype none

module mbet_iter import mbet_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [LimitWidth-1:0] limit_i,
  input  wire head_t                 head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [COUNT_WIDTH-1:0]     escape_count_o
);

  localparam int unsigned ProdWidth  = 2 * WordWidth;
  localparam int unsigned SumWidth   = ProdWidth + 1;
  localparam int unsigned BoundShift = 2 * FRAC_BITS + 2;
  localparam logic [ProdWidth-1:0] EscBound =
    (BoundShift >= ProdWidth) ? {ProdWidth{1'b1}} : (ProdWidth'(1) << BoundShift);

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_DONE
  } back_state_e;

  back_state_e                  state_q;
  logic                         fresh_q;
  logic [LimitWidth-1:0]        n_q, n_eff;
  logic [LimitWidth-1:0]        res_q;
  logic                         out_valid_q;
  logic [COUNT_WIDTH-1:0]       out_count_q;
  logic signed [WordWidth-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic signed [ProdWidth-1:0]  rr_q, ii_q, ri_q;
  logic signed [ProdWidth-1:0]  rr_c, ii_c, ri_c;
  logic signed [ProdWidth-1:0]  diff, shr_re, shr_im;
  logic signed [SumWidth-1:0]   sum_re, sum_im;
  logic [WordWidth-1:0]         zr_new, zi_new;
  logic [ProdWidth-1:0]         mag;
  logic                         escaped, at_limit;
  logic                         load_out;

  function automatic logic [WordWidth-1:0] sat_word(input logic [SumWidth-1:0] v);
    logic [SumWidth-WordWidth:0] hi;
    hi = v[SumWidth-1:WordWidth-1];
    if ((&hi) || !(|hi)) begin
      return v[WordWidth-1:0];
    end
    return v[SumWidth-1] ? WordMin : WordMax;
  endfunction

  assign rr_c = zr_q * zr_q;
  assign ii_c = zi_q * zi_q;
  assign ri_c = zr_q * zi_q;

  // z' = z^2 + c, products truncated toward minus infinity
  assign diff   = rr_q - ii_q;
  assign shr_re = diff >>> FRAC_BITS;
  assign shr_im = ri_q >>> (FRAC_BITS - 1);
  assign sum_re = SumWidth'(shr_re) + SumWidth'(cr_q);
  assign sum_im = SumWidth'(shr_im) + SumWidth'(ci_q);
  assign zr_new = sat_word(sum_re);
  assign zi_new = sat_word(sum_im);

  // Squares in rr_q/ii_q belong to the z produced by the previous iteration
  assign mag      = $unsigned(rr_q) + $unsigned(ii_q);
  assign escaped  = !fresh_q && (mag > EscBound);
  assign n_eff    = fresh_q ? n_q : n_q + 1'b1;
  assign at_limit = (n_eff >= limit_i);

  // Load the output register when it is empty or drains this cycle
  assign load_out = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  assign pop_o          = (state_q == B_IDLE) && head_i.valid;
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      case (state_q)
        B_IDLE: begin
          if (head_i.valid) begin
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          state_q <= B_ADD;
        end
        B_ADD: begin
          state_q <= (escaped || at_limit) ? B_DONE : B_MUL;
        end
        B_DONE: begin
          if (load_out) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (head_i.valid) begin
          cr_q    <= head_i.point.c_real;
          ci_q    <= head_i.point.c_imag;
          zr_q    <= '0;
          zi_q    <= '0;
          n_q     <= '0;
          fresh_q <= 1'b1;
        end
      end
      B_MUL: begin
        rr_q <= rr_c;
        ii_q <= ii_c;
        ri_q <= ri_c;
      end
      B_ADD: begin
        if (escaped) begin
          res_q <= n_q;
        end else if (at_limit) begin
          res_q <= n_eff;
        end else begin
          zr_q    <= $signed(zr_new);
          zi_q    <= $signed(zi_new);
          n_q     <= n_eff;
          fresh_q <= 1'b0;
        end
      end
      B_DONE: begin
        if (load_out) begin
          out_count_q <= COUNT_WIDTH'(res_q);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ADD) |-> (n_q <= limit_i))
    else $error("iteration count passed the limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |-> (res_q <= limit_i))
    else $error("result above the limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL && fresh_q) |-> (zr_q == '0 && zi_q == '0 && n_q == '0))
    else $error("first iteration does not start from zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == B_MUL))
    else $error("pop did not start an iteration");
`endif

endmodule

`default_nettype wire
